>>> sv/bfs_level_layout_core_macros.svh
// ----------------------------------------------------------------------------
// bfs level layout assertion macros
// shared assertion forms for the layout core checker
// ----------------------------------------------------------------------------
`ifndef BFS_LEVEL_LAYOUT_CORE_MACROS_SVH
`define BFS_LEVEL_LAYOUT_CORE_MACROS_SVH

// same-cycle implication
`define BLL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bll_pkg.sv
// ----------------------------------------------------------------------------
// bll_pkg
// types, widths and constants of the bfs level layout core
// ----------------------------------------------------------------------------
package bll_pkg;

    localparam int DEF_MAX_NODES  = 64;
    localparam int DEF_MAX_DEGREE = 8;
    localparam int DEF_STEP       = 10;

    localparam int NODE_W     = 6;
    localparam int X_W        = 13;
    localparam int Y_W        = 10;
    localparam int LEVEL_W    = 7;
    localparam int CNT_W      = 7;
    localparam int REQ_W      = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [X_W-1:0]   X_MAX            = 13'd8191;
    localparam logic [Y_W-1:0]   Y_MAX            = 10'd1023;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_RUN   = 2'd2
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_OUT,
        ST_RUN_INIT,
        ST_POP,
        ST_PARENT,
        ST_DEGREE,
        ST_EDGE,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [X_W-1:0]     x;
    } node_rec_t;

    typedef struct packed {
        logic in_valid;
        req_t req;
        logic queue_busy;
        logic has_edges;
        logic edge_more;
        logic out_free;
        logic out_final;
    } status_t;

    typedef struct packed {
        logic in_ready;
        logic clear_deg;
        logic add_write;
        logic add_emit;
        logic run_init;
        logic pop;
        logic parent_read;
        logic degree_load;
        logic edge_step;
        logic out_emit;
    } ctrl_t;

endpackage

>>> sv/bfs_level_layout_core.sv
// ----------------------------------------------------------------------------
// bfs_level_layout_core
// layered breadth-first layout of a small directed graph
// ----------------------------------------------------------------------------
// input items (s_axis): tuser carries the request, tdata the edge endpoints.
// a clear item empties all adjacency lists and gives no result. an add-edge
// item appends dst to src's list and returns one result with tlast set, via
// ADD_RD, ADD_WR and ADD_OUT. a run item walks breadth-first from node 0
// through the queue, degree, neighbour and node rams, one ram access step per
// cycle unless the output stalls: RUN_INIT, then POP, PARENT, DEGREE and one
// EDGE per stored edge for each dequeued node, a POP that sees the queue
// empty, then OUT_RD and OUT_WAIT per reported node. results come one per
// active node in index order, tlast on the last. the block takes no new item
// while an item is in progress. a result waits in the output register while
// m_axis_tready is low, and the sequencer holds. the user must write node_count
// through cfg_wr_en / cfg_wr_data only while idle; this is not enforced.
// reset (synchronous, active low) empties all lists, sets node_count to 64
// and drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bfs_level_layout_core
    import bll_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int STEP       = DEF_STEP
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CNT_W-1:0]      cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // src_node[5:0], dst_node[11:6], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // node_index[5:0], x_coord[18:6], y_coord[28:19], reached[29],
    // edge_dropped[30], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int NA = $clog2(MAX_NODES * MAX_DEGREE);
    localparam int RW = $bits(node_rec_t);

    ctrl_t   ctl;
    status_t stat;

    logic [CNT_W-1:0]  node_count_reg;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [NODE_W-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [NW-1:0]     parent_reg, parent_next;
    logic [DW-1:0]     deg_reg, deg_next;
    logic [DW-1:0]     e_reg, e_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [X_W-1:0]    xcur_reg, xcur_next;
    logic              dropped_reg, dropped_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [MAX_NODES-1:0] dvalid_reg, dvalid_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic              in_fire;
    logic [CNT_W-1:0]  n_active;
    logic [NW-1:0]     src_idx, q_idx, nb_idx, idx_idx, tail_idx, head_idx;
    logic [NODE_W-1:0] q_rd, nb;
    logic [DW-1:0]     deg_rd, deg_cur, deg_eff;
    node_rec_t         node_rd, node_wdata;
    logic              add_ok, take, tail_room, vis;
    logic [X_W:0]      x_sum;
    logic [X_W-1:0]    x_sat, x_out;
    logic [15:0]       y_full;
    logic [Y_W-1:0]    y_out;

    logic              deg_we;
    logic [NW-1:0]     deg_raddr;
    logic [DW-1:0]     deg_wdata;
    logic              nbr_we;
    logic [NA-1:0]     nbr_waddr, nbr_raddr;
    logic              node_we;
    logic [NW-1:0]     node_waddr, node_raddr;
    logic              q_we;
    logic [NW-1:0]     q_waddr;
    logic [NODE_W-1:0] q_wdata;

    logic [NODE_W-1:0] nbr_rd_w;
    logic [DW-1:0]     deg_rd_w;
    logic [RW-1:0]     node_rd_w;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    assign n_active = (node_count_reg == '0) ? CNT_W'(1) :
                      (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
                      node_count_reg;

    assign in_fire  = s_axis_tvalid && ctl.in_ready;
    assign src_idx  = src_reg[NW-1:0];
    assign q_idx    = q_rd[NW-1:0];
    assign nb       = nbr_rd_w;
    assign nb_idx   = nb[NW-1:0];
    assign idx_idx  = idx_reg[NW-1:0];
    assign tail_idx = tail_reg[NW-1:0];
    assign head_idx = head_reg[NW-1:0];

    assign deg_rd  = deg_rd_w;
    assign node_rd = node_rd_w;

    assign deg_cur   = dvalid_reg[src_idx] ? deg_rd : '0;
    assign deg_eff   = dvalid_reg[parent_reg] ? deg_rd : '0;
    assign add_ok    = ({1'b0, src_reg} < CNT_W'(MAX_NODES)) &&
                       ({1'b0, dst_reg} < CNT_W'(MAX_NODES)) &&
                       (deg_cur < DW'(MAX_DEGREE));
    assign take      = ({1'b0, nb} < n_reg) && !visited_reg[nb_idx];
    assign tail_room = tail_reg < CNT_W'(MAX_NODES);

    // saturating step adder for the x coordinate
    assign x_sum = {1'b0, xcur_reg} + (X_W + 1)'(STEP);
    assign x_sat = (x_sum > {1'b0, X_MAX}) ? X_MAX : x_sum[X_W-1:0];

    // report path
    assign vis    = visited_reg[idx_idx];
    assign y_full = 16'(int'(node_rd.level) * STEP);
    assign y_out  = (y_full > 16'(Y_MAX)) ? Y_MAX : y_full[Y_W-1:0];
    assign x_out  = node_rd.x;

    // status to sequencer
    always_comb begin
        stat.in_valid   = s_axis_tvalid;
        stat.req        = req_t'(s_axis_tuser);
        stat.queue_busy = (head_reg < tail_reg) && (head_reg < CNT_W'(MAX_NODES));
        stat.has_edges  = deg_eff != '0;
        stat.edge_more  = (e_reg + DW'(1)) < deg_reg;
        stat.out_free   = !m_valid_reg || m_axis_tready;
        stat.out_final  = (idx_reg + CNT_W'(1)) == n_reg;
    end

    bll_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    // ram ports
    always_comb begin
        deg_we    = ctl.add_write && add_ok;
        deg_wdata = deg_cur + DW'(1);
        deg_raddr = ctl.parent_read ? q_idx : src_idx;

        nbr_we    = ctl.add_write && add_ok;
        nbr_waddr = NA'(int'(src_idx) * MAX_DEGREE + int'(deg_cur));
        nbr_raddr = ctl.edge_step ?
                    NA'(int'(parent_reg) * MAX_DEGREE + int'(e_reg) + 1) :
                    NA'(int'(parent_reg) * MAX_DEGREE);

        node_we    = ctl.run_init || (ctl.edge_step && take);
        node_waddr = ctl.run_init ? '0 : nb_idx;
        node_wdata.level = ctl.run_init ? '0 : level_reg;
        node_wdata.x     = ctl.run_init ? '0 : xcur_reg;
        node_raddr = ctl.parent_read ? q_idx : idx_idx;

        q_we    = ctl.run_init || (ctl.edge_step && take && tail_room);
        q_waddr = ctl.run_init ? '0 : tail_idx;
        q_wdata = ctl.run_init ? '0 : nb;
    end

    bll_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_degree_ram (
        .clk     (aclk),
        .wr_en   (deg_we),
        .wr_addr (src_idx),
        .wr_data (deg_wdata),
        .rd_addr (deg_raddr),
        .rd_data (deg_rd_w)
    );

    bll_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_DEGREE)) u_nbr_ram (
        .clk     (aclk),
        .wr_en   (nbr_we),
        .wr_addr (nbr_waddr),
        .wr_data (dst_reg),
        .rd_addr (nbr_raddr),
        .rd_data (nbr_rd_w)
    );

    bll_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk     (aclk),
        .wr_en   (node_we),
        .wr_addr (node_waddr),
        .wr_data (node_wdata),
        .rd_addr (node_raddr),
        .rd_data (node_rd_w)
    );

    bll_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .clk     (aclk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (q_wdata),
        .rd_addr (head_idx),
        .rd_data (q_rd)
    );

    // datapath registers
    always_comb begin
        src_next     = src_reg;
        dst_next     = dst_reg;
        n_next       = n_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        idx_next     = idx_reg;
        parent_next  = parent_reg;
        deg_next     = deg_reg;
        e_next       = e_reg;
        level_next   = level_reg;
        xcur_next    = xcur_reg;
        dropped_next = dropped_reg;
        visited_next = visited_reg;
        dvalid_next  = dvalid_reg;

        if (in_fire) begin
            src_next = s_axis_tdata[NODE_W-1:0];
            dst_next = s_axis_tdata[2*NODE_W-1:NODE_W];
            n_next   = n_active;
        end
        if (ctl.clear_deg) begin
            dvalid_next = '0;
        end
        if (ctl.add_write) begin
            dropped_next = !add_ok;
            if (add_ok) begin
                dvalid_next[src_idx] = 1'b1;
            end
        end
        if (ctl.run_init) begin
            visited_next    = '0;
            visited_next[0] = 1'b1;
            head_next       = '0;
            tail_next       = CNT_W'(1);
            idx_next        = '0;
        end
        if (ctl.pop) begin
            head_next = head_reg + CNT_W'(1);
        end
        if (ctl.parent_read) begin
            parent_next = q_idx;
        end
        if (ctl.degree_load) begin
            deg_next   = deg_eff;
            e_next     = '0;
            level_next = node_rd.level + LEVEL_W'(1);
            xcur_next  = node_rd.x;
        end
        if (ctl.edge_step) begin
            e_next = e_reg + DW'(1);
            if (take) begin
                visited_next[nb_idx] = 1'b1;
                xcur_next            = x_sat;
                if (tail_room) begin
                    tail_next = tail_reg + CNT_W'(1);
                end
            end
        end
        if (ctl.out_emit) begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.add_emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, dropped_reg, 1'b0, {Y_W{1'b0}}, {X_W{1'b0}}, src_reg};
            m_last_next  = 1'b1;
        end else if (ctl.out_emit) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, 1'b0, vis,
                            vis ? y_out : {Y_W{1'b0}},
                            vis ? x_out : {X_W{1'b0}},
                            idx_reg[NODE_W-1:0]};
            m_last_next  = stat.out_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            idx_reg     <= '0;
            visited_reg <= '0;
            dvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            idx_reg     <= idx_next;
            visited_reg <= visited_next;
            dvalid_reg  <= dvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        n_reg       <= n_next;
        parent_reg  <= parent_next;
        deg_reg     <= deg_next;
        e_reg       <= e_next;
        level_reg   <= level_next;
        xcur_reg    <= xcur_next;
        dropped_reg <= dropped_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

>>> sv/bll_ram.sv
// ----------------------------------------------------------------------------
// bll_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bll_ctrl.sv
// ----------------------------------------------------------------------------
// bll_ctrl
// sequencer for edge loading, breadth-first walk and result readout
// ----------------------------------------------------------------------------
module bll_ctrl
    import bll_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t stat,
    output ctrl_t   ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.in_valid) begin
                    case (stat.req)
                        REQ_ADD: state_next = ST_ADD_RD;
                        REQ_RUN: state_next = ST_RUN_INIT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD:   state_next = ST_ADD_WR;
            ST_ADD_WR:   state_next = ST_ADD_OUT;
            ST_ADD_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN_INIT: state_next = ST_POP;
            ST_POP: begin
                state_next = stat.queue_busy ? ST_PARENT : ST_OUT_RD;
            end
            ST_PARENT:   state_next = ST_DEGREE;
            ST_DEGREE: begin
                state_next = stat.has_edges ? ST_EDGE : ST_POP;
            end
            ST_EDGE: begin
                state_next = stat.edge_more ? ST_EDGE : ST_POP;
            end
            ST_OUT_RD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (stat.out_free) begin
                    state_next = stat.out_final ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctl.in_ready  = 1'b1;
                ctl.clear_deg = stat.in_valid && (stat.req == REQ_CLEAR);
            end
            ST_ADD_WR:   ctl.add_write   = 1'b1;
            ST_ADD_OUT:  ctl.add_emit    = stat.out_free;
            ST_RUN_INIT: ctl.run_init    = 1'b1;
            ST_POP:      ctl.pop         = stat.queue_busy;
            ST_PARENT:   ctl.parent_read = 1'b1;
            ST_DEGREE:   ctl.degree_load = 1'b1;
            ST_EDGE:     ctl.edge_step   = 1'b1;
            ST_OUT_WAIT: ctl.out_emit    = stat.out_free;
            default:     ctl = '0;
        endcase
    end

endmodule

>>> sv/bll_checker.sv
// ----------------------------------------------------------------------------
// bll_checker
// port-level checks for the bfs level layout core
// ----------------------------------------------------------------------------
`include "bfs_level_layout_core_macros.svh"

module bll_checker
    import bll_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [REQ_W-1:0]      s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    `BLL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")

    `BLL_ASSERT_NEXT(a_busy_after_work, aclk, aresetn, s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_ADD || s_axis_tuser == REQ_RUN), !s_axis_tready, "ready while item in progress")

    `BLL_ASSERT_SAME(a_drop_is_edge_ack, aclk, aresetn, m_axis_tvalid && m_axis_tdata[30], m_axis_tlast && !m_axis_tdata[29] && (m_axis_tdata[28:6] == '0), "dropped flag on a run item")

    `BLL_ASSERT_SAME(a_origin_coords, aclk, aresetn, m_axis_tvalid && (!m_axis_tdata[29] || m_axis_tdata[5:0] == '0), m_axis_tdata[28:6] == '0, "nonzero coordinates for root or unreached node")

endmodule

bind bfs_level_layout_core bll_checker u_bll_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the breadth-first layered layout core
// ----------------------------------------------------------------------------
// drives clear, add-edge and run items into the stream input and predicts
// every coordinate result from its own copy of the adjacency lists and the
// node count. a short directed table comes first (empty graph, list
// overflow, node count extremes, ignored request code), then random graphs
// built from varied node counts, each ended by a run. the three random passes
// use different sender and receiver idle rates, the last one none at all.
// ----------------------------------------------------------------------------
module tb;
    import bll_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES  = 64;
    localparam int PASS_ITEMS   = 120;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic [X_W-1:0]    x_coord;
        logic [Y_W-1:0]    y_coord;
        logic              reached;
        logic              edge_dropped;
        logic              last;
    } coord_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CNT_W-1:0]   cfg;
        logic [REQ_W-1:0]   req;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  dst;
        coord_t             res;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    stim_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd1,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd2,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd1,  6'd63, '{6'd1,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd63, 6'd0,  '{6'd63, 13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd2,  6'd1,  '{6'd2,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0},
        '{ROW_PREDICT, 7'd0,   REQ_UNUSED, 6'd63, 6'd63, '0},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd3,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd4,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd5,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd6,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd7,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd8,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b0, 1'b1}},
        '{ROW_TYPED,   7'd0,   REQ_ADD,    6'd0,  6'd9,  '{6'd0,  13'd0, 10'd0, 1'b0, 1'b1, 1'b1}},
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0},
        '{ROW_CONFIG,  7'd5,   REQ_CLEAR,  6'd0,  6'd0,  '0},
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0},
        '{ROW_CONFIG,  7'd0,   REQ_CLEAR,  6'd0,  6'd0,  '0},
        '{ROW_TYPED,   7'd0,   REQ_RUN,    6'd0,  6'd0,  '{6'd0,  13'd0, 10'd0, 1'b1, 1'b0, 1'b1}},
        '{ROW_CONFIG,  7'd127, REQ_CLEAR,  6'd0,  6'd0,  '0},
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0},
        '{ROW_PREDICT, 7'd0,   REQ_CLEAR,  6'd0,  6'd0,  '0},
        '{ROW_PREDICT, 7'd0,   REQ_RUN,    6'd0,  6'd0,  '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]      cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // predictor state
    logic [NODE_W-1:0] adj_list [0:DEF_MAX_NODES-1][0:DEF_MAX_DEGREE-1];
    int                adj_degree [0:DEF_MAX_NODES-1];
    logic [CNT_W-1:0]  node_limit = NODE_COUNT_RESET;

    coord_t pending_coords [$];
    coord_t fresh_coords [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int runs_done = 0;
    int edges_dropped = 0;
    int unreached_seen = 0;

    bfs_level_layout_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic int active_nodes();
        if (node_limit == 0) begin
            return 1;
        end
        if (node_limit > DEF_MAX_NODES) begin
            return DEF_MAX_NODES;
        end
        return int'(node_limit);
    endfunction

    // updates the graph copy and leaves the results of one item in fresh_coords
    function automatic void layout_predict(input logic [REQ_W-1:0] req,
                                           input logic [NODE_W-1:0] src,
                                           input logic [NODE_W-1:0] dst);
        coord_t r;
        int     n;
        int     parent;
        int     nb;
        int     k;
        int     xv;
        int     yv;
        bit     seen [0:DEF_MAX_NODES-1];
        int     level [0:DEF_MAX_NODES-1];
        int     xpos [0:DEF_MAX_NODES-1];
        int     walk_queue [$];
        fresh_coords.delete();
        case (req)
            REQ_CLEAR: begin
                foreach (adj_degree[i]) adj_degree[i] = 0;
            end
            REQ_ADD: begin
                r = '0;
                r.node_index = src;
                r.last = 1'b1;
                if (adj_degree[src] >= DEF_MAX_DEGREE) begin
                    r.edge_dropped = 1'b1;
                    edges_dropped++;
                end else begin
                    adj_list[src][adj_degree[src]] = dst;
                    adj_degree[src]++;
                end
                fresh_coords.push_back(r);
            end
            REQ_RUN: begin
                n = active_nodes();
                for (int i = 0; i < DEF_MAX_NODES; i++) begin
                    seen[i] = 1'b0;
                    level[i] = 0;
                    xpos[i] = 0;
                end
                seen[0] = 1'b1;
                walk_queue.push_back(0);
                while (walk_queue.size() != 0) begin
                    parent = walk_queue.pop_front();
                    k = 1;
                    for (int e = 0; e < adj_degree[parent]; e++) begin
                        nb = int'(adj_list[parent][e]);
                        if (nb >= n || seen[nb]) begin
                            continue;
                        end
                        seen[nb] = 1'b1;
                        level[nb] = level[parent] + 1;
                        xv = xpos[parent] + DEF_STEP * (k - 1);
                        xpos[nb] = (xv > int'(X_MAX)) ? int'(X_MAX) : xv;
                        k++;
                        walk_queue.push_back(nb);
                    end
                end
                for (int i = 0; i < n; i++) begin
                    r = '0;
                    r.node_index = i[NODE_W-1:0];
                    if (seen[i]) begin
                        yv = level[i] * DEF_STEP;
                        r.x_coord = xpos[i][X_W-1:0];
                        r.y_coord = (yv > int'(Y_MAX)) ? Y_MAX : yv[Y_W-1:0];
                        r.reached = 1'b1;
                    end else begin
                        unreached_seen++;
                    end
                    r.last = (i == n - 1);
                    fresh_coords.push_back(r);
                end
                runs_done++;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [NODE_W-1:0] src,
                                input logic [NODE_W-1:0] dst,
                                input bit typed,
                                input coord_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - 2 * NODE_W){1'b0}}, dst, src};
        s_axis_tuser <= req;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        layout_predict(req, src, dst);
        if (req != REQ_UNUSED) begin
            items_sent++;
        end
        if (typed) begin
            pending_coords.push_back(typed_res);
        end else begin
            foreach (fresh_coords[i]) pending_coords.push_back(fresh_coords[i]);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_coords.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        node_limit = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random graphs: mostly clear, a burst of edges, then a run
    task automatic random_graphs(input int target);
        int          start;
        int          n;
        int          pick;
        int          hub;
        bit          use_hub;
        bit          first;
        logic [CNT_W-1:0]  value;
        logic [NODE_W-1:0] s;
        logic [NODE_W-1:0] d;
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < target) begin
            if (first || $urandom_range(0, 99) < 30) begin
                case ($urandom_range(0, 9))
                    0: value = 7'd0;
                    1: value = 7'd1;
                    2: value = 7'd64;
                    3: value = 7'($urandom_range(65, 127));
                    default: value = 7'($urandom_range(2, 20));
                endcase
                set_node_count(value);
                first = 1'b0;
            end
            n = active_nodes();
            if ($urandom_range(0, 99) < 85) begin
                send_request(REQ_CLEAR, 6'($urandom), 6'($urandom), 1'b0, '0);
            end
            use_hub = ($urandom_range(0, 99) < 15);
            hub = (use_hub && $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, n - 1);
            repeat ($urandom_range(3, 18)) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    send_request(REQ_UNUSED, 6'($urandom), 6'($urandom), 1'b0, '0);
                end else if (pick < 8) begin
                    send_request(REQ_RUN, 6'($urandom), 6'($urandom), 1'b0, '0);
                end else begin
                    if (use_hub && $urandom_range(0, 2) != 0) begin
                        s = hub[NODE_W-1:0];
                    end else if (pick < 90) begin
                        s = 6'($urandom_range(0, n - 1));
                    end else begin
                        s = 6'($urandom_range(0, 63));
                    end
                    if ($urandom_range(0, 99) < 88) begin
                        d = 6'($urandom_range(0, n - 1));
                    end else begin
                        d = 6'($urandom_range(0, 63));
                    end
                    send_request(REQ_ADD, s, d, 1'b0, '0);
                end
            end
            send_request(REQ_RUN, 6'($urandom), 6'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        coord_t want;
        coord_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.node_index = m_axis_tdata[5:0];
            got.x_coord = m_axis_tdata[18:6];
            got.y_coord = m_axis_tdata[28:19];
            got.reached = m_axis_tdata[29];
            got.edge_dropped = m_axis_tdata[30];
            got.last = m_axis_tlast;
            if (pending_coords.size() == 0) begin
                $error("unexpected result: node_index %0d", got.node_index);
                error_count++;
            end else begin
                want = pending_coords.pop_front();
                results_checked++;
                if (got.node_index != want.node_index) begin
                    $error("node_index: expected %0d, got %0d", want.node_index, got.node_index);
                    error_count++;
                end
                if (got.x_coord != want.x_coord) begin
                    $error("x_coord: expected %0d, got %0d", want.x_coord, got.x_coord);
                    error_count++;
                end
                if (got.y_coord != want.y_coord) begin
                    $error("y_coord: expected %0d, got %0d", want.y_coord, got.y_coord);
                    error_count++;
                end
                if (got.reached != want.reached) begin
                    $error("reached: expected %0d, got %0d", want.reached, got.reached);
                    error_count++;
                end
                if (got.edge_dropped != want.edge_dropped) begin
                    $error("edge_dropped: expected %0d, got %0d",
                           want.edge_dropped, got.edge_dropped);
                    error_count++;
                end
                if (got.last != want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (adj_degree[i]) adj_degree[i] = 0;
        send_idle_pct = 18;
        recv_idle_pct = 58;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                set_node_count(directed_rows[i].cfg);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].src, directed_rows[i].dst,
                             directed_rows[i].kind == ROW_TYPED, directed_rows[i].res);
            end
        end

        random_graphs(PASS_ITEMS);
        send_idle_pct = 58;
        recv_idle_pct = 18;
        random_graphs(PASS_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_graphs(PASS_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (pending_coords.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_coords.size() != 0) begin
            $error("%0d results never arrived", pending_coords.size());
            error_count++;
        end

        $display("summary: %0d items, %0d results checked, %0d layout runs",
                 items_sent, results_checked, runs_done);
        $display("summary: %0d edges dropped on full lists, %0d unreached nodes reported",
                 edges_dropped, unreached_seen);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
